// File: src/gld_pkg.sv
// Shared types and constants for the GIF LZW decoder.
package gld_pkg;

  localparam int unsigned BufBits   = 24;
  localparam int unsigned CountBits = 5;
  localparam int unsigned WidthBits = 4;
  localparam int unsigned MinBits   = 4;

  localparam logic [MinBits-1:0] MinCodeReset = 4'd8;
  localparam logic [MinBits-1:0] MinCodeLow   = 4'd2;
  localparam logic [MinBits-1:0] MinCodeHigh  = 4'd8;
  localparam logic [CountBits-1:0] PushLimit  = 5'd16;

  localparam logic REG_MIN_CODE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_PULL  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_REFUSED = 3'd2,
    ST_NEED    = 3'd3,
    ST_END     = 3'd4,
    ST_ILLEGAL = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_RUN = 2'd0,
    PH_END = 2'd1,
    PH_ERR = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK_RD,
    S_WALK,
    S_ROOT,
    S_POP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } bb_ctrl_t;

endpackage

// File: src/gld_bitbuf.sv
// Bit buffer that collects compressed bytes and hands out variable-width codes.
module gld_bitbuf
  import gld_pkg::*;
#(
  parameter int unsigned CodeBits = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bb_ctrl_t             ctrl_i,
  input  logic [7:0]           byte_i,
  input  logic [WidthBits-1:0] width_i,
  output logic [CodeBits-1:0]  code_o,
  output logic [CountBits-1:0] count_o
);

  logic [BufBits-1:0]   buf_q, buf_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [BufBits-1:0]   mask;

  assign mask    = (BufBits'(1) << width_i) - BufBits'(1);
  assign code_o  = CodeBits'(buf_q & mask);
  assign count_o = cnt_q;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      buf_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.push) begin
      buf_d = buf_q | (BufBits'(byte_i) << cnt_q);
      cnt_d = cnt_q + CountBits'(8);
    end else if (ctrl_i.pop) begin
      buf_d = buf_q >> width_i;
      cnt_d = cnt_q - CountBits'(width_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/gld_dict.sv
// Dictionary memory holding the prefix code and suffix byte of each entry.
module gld_dict
  import gld_pkg::*;
#(
  parameter int unsigned CodeBits = 12
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [CodeBits-1:0] wr_addr_i,
  input  logic [CodeBits-1:0] wr_prefix_i,
  input  logic [7:0]          wr_suffix_i,
  input  logic [CodeBits-1:0] rd_addr_i,
  output logic [CodeBits-1:0] rd_prefix_o,
  output logic [7:0]          rd_suffix_o
);

  localparam int unsigned Depth = 1 << CodeBits;

  logic [CodeBits+7:0] mem [Depth];
  logic [CodeBits+7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_prefix_i, wr_suffix_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_prefix_o = rd_q[CodeBits+7:8];
  assign rd_suffix_o = rd_q[7:0];

endmodule

// File: src/gld_stack.sv
// String stack memory that holds the bytes of one expanded code.
module gld_stack
  import gld_pkg::*;
#(
  parameter int unsigned AddrBits = 12
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrBits-1:0] wr_addr_i,
  input  logic [7:0]          wr_data_i,
  input  logic [AddrBits-1:0] rd_addr_i,
  output logic [7:0]          rd_data_o
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// File: src/gif_lzw_decoder.sv
// Top level of the GIF LZW decoder: sequencer, dictionary walk and register port.
// A push request and every pull request give one result each; a start request gives none.
// A pull request that decodes a code reads its string from the dictionary one entry at a time
// through the single dictionary read port, and decodes again after each clear code consumed on the way.
// Reset is asynchronous; the dictionary and the stack memories are not cleared.
module gif_lzw_decoder
  import gld_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   mode_i,
  input  logic [7:0]   data_byte_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [7:0]   pixel_o,
  output logic [2:0]   status_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned CB = MAX_CODE_BITS;
  localparam int unsigned NB = MAX_CODE_BITS + 1;
  localparam logic [NB-1:0] TableSize = NB'(1) << CB;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [MinBits-1:0]   min_code_size_q;
  logic [MinBits-1:0]   active_min_q, active_min_d;
  logic [WidthBits-1:0] code_width_q, code_width_d;
  logic [NB-1:0]        next_free_q, next_free_d;
  logic [CB-1:0]        prev_code_q, prev_code_d;
  logic                 prev_valid_q, prev_valid_d;
  logic [7:0]           prev_first_q, prev_first_d;
  logic                 kwk_q, kwk_d;
  logic [NB-1:0]        level_q, level_d;
  logic                 out_valid_q, out_valid_d;
  logic [CB-1:0]        code_q, code_d;
  logic [CB-1:0]        cur_q, cur_d;
  logic [7:0]           root_q, root_d;
  logic [7:0]           pixel_q, pixel_d;
  status_e              status_q, status_d;

  bb_ctrl_t             bb_ctrl;
  logic [CB-1:0]        bb_code;
  logic [CountBits-1:0] bb_count;

  logic                 dict_we;
  logic [CB-1:0]        dict_waddr;
  logic [CB-1:0]        dict_wprefix;
  logic [7:0]           dict_wsuffix;
  logic [CB-1:0]        dict_raddr;
  logic [CB-1:0]        dict_rprefix;
  logic [7:0]           dict_rsuffix;

  logic                 stk_we;
  logic [7:0]           stk_wdata;
  logic [NB-1:0]        level_dec;
  logic [7:0]           stk_rdata;

  logic                 in_fire, out_free, cfg_write, have_code, table_open, grow;
  logic [MinBits-1:0]   min_clamped;
  logic [NB-1:0]        clear_code, code_ext, prefix_ext, next_free_inc;
  mode_e                mode;

  assign mode       = mode_e'(mode_i);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MIN_CODE_SIZE);
  assign prdata    = (paddr[2] == REG_MIN_CODE_SIZE) ? 32'(min_code_size_q) : '0;

  always_comb begin
    min_clamped = min_code_size_q;
    if (min_code_size_q < MinCodeLow) begin
      min_clamped = MinCodeLow;
    end else if (min_code_size_q > MinCodeHigh) begin
      min_clamped = MinCodeHigh;
    end
  end

  assign clear_code    = NB'(1) << active_min_q;
  assign code_ext      = NB'(bb_code);
  assign prefix_ext    = NB'(dict_rprefix);
  assign have_code     = bb_count >= CountBits'(code_width_q);
  assign table_open    = next_free_q < TableSize;
  assign next_free_inc = next_free_q + NB'(1);
  assign grow          = (next_free_inc == (NB'(1) << code_width_q)) &&
                         (next_free_inc < TableSize);
  assign level_dec     = level_q - NB'(1);

  assign dict_raddr = (state_q == S_WALK) ? dict_rprefix : cur_q;
  assign dict_waddr = next_free_q[CB-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && mode == MODE_PULL) begin
          state_d = (level_q != '0) ? S_POP : S_DECODE;
        end
      end
      S_DECODE: begin
        if (out_free) begin
          if (phase_q != PH_RUN || !have_code) begin
            state_d = S_IDLE;
          end else if (code_ext == clear_code + NB'(1)) begin
            state_d = S_IDLE;
          end else if (code_ext == clear_code) begin
            state_d = S_DECODE;
          end else if (code_ext < next_free_q) begin
            state_d = (code_ext < clear_code) ? S_ROOT : S_WALK_RD;
          end else if (code_ext == next_free_q && prev_valid_q && table_open) begin
            state_d = S_WALK_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_WALK_RD: state_d = S_WALK;
      S_WALK: begin
        if (prefix_ext < clear_code) begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: state_d = S_POP;
      S_POP:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and output logic of the sequencer.
  always_comb begin
    phase_d      = phase_q;
    active_min_d = active_min_q;
    code_width_d = code_width_q;
    next_free_d  = next_free_q;
    prev_code_d  = prev_code_q;
    prev_valid_d = prev_valid_q;
    prev_first_d = prev_first_q;
    kwk_d        = kwk_q;
    level_d      = level_q;
    code_d       = code_q;
    cur_d        = cur_q;
    root_d       = root_q;
    pixel_d      = pixel_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    bb_ctrl      = '0;
    dict_we      = 1'b0;
    dict_wprefix = prev_code_q;
    dict_wsuffix = prev_first_q;
    stk_we       = 1'b0;
    stk_wdata    = root_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (mode)
            MODE_START: begin
              active_min_d = min_clamped;
              code_width_d = WidthBits'(min_clamped) + WidthBits'(1);
              next_free_d  = (NB'(1) << min_clamped) + NB'(2);
              prev_code_d  = '0;
              prev_valid_d = 1'b0;
              level_d      = '0;
              phase_d      = PH_RUN;
              bb_ctrl.clear = 1'b1;
            end
            MODE_PUSH: begin
              out_valid_d = 1'b1;
              pixel_d     = '0;
              if (bb_count > PushLimit) begin
                status_d = ST_REFUSED;
              end else begin
                status_d     = ST_TAKEN;
                bb_ctrl.push = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DECODE: begin
        if (out_free) begin
          pixel_d = '0;
          if (phase_q == PH_END) begin
            out_valid_d = 1'b1;
            status_d    = ST_END;
          end else if (phase_q != PH_RUN) begin
            out_valid_d = 1'b1;
            status_d    = ST_ILLEGAL;
          end else if (!have_code) begin
            out_valid_d = 1'b1;
            status_d    = ST_NEED;
          end else begin
            bb_ctrl.pop = 1'b1;
            code_d      = bb_code;
            cur_d       = bb_code;
            root_d      = bb_code[7:0];
            kwk_d       = 1'b0;
            if (code_ext == clear_code + NB'(1)) begin
              phase_d     = PH_END;
              out_valid_d = 1'b1;
              status_d    = ST_END;
            end else if (code_ext == clear_code) begin
              code_width_d = WidthBits'(active_min_q) + WidthBits'(1);
              next_free_d  = clear_code + NB'(2);
              prev_code_d  = '0;
              prev_valid_d = 1'b0;
            end else if (code_ext < next_free_q) begin
              kwk_d = 1'b0;
            end else if (code_ext == next_free_q && prev_valid_q && table_open) begin
              kwk_d       = 1'b1;
              dict_we     = 1'b1;
              next_free_d = next_free_inc;
              if (grow) begin
                code_width_d = code_width_q + WidthBits'(1);
              end
            end else begin
              phase_d     = PH_ERR;
              out_valid_d = 1'b1;
              status_d    = ST_ILLEGAL;
            end
          end
        end
      end
      S_WALK: begin
        stk_we    = 1'b1;
        stk_wdata = dict_rsuffix;
        level_d   = level_q + NB'(1);
        cur_d     = dict_rprefix;
        root_d    = dict_rprefix[7:0];
      end
      S_ROOT: begin
        stk_we       = 1'b1;
        level_d      = level_q + NB'(1);
        dict_wsuffix = root_q;
        if (!kwk_q && prev_valid_q && table_open) begin
          dict_we     = 1'b1;
          next_free_d = next_free_inc;
          if (grow) begin
            code_width_d = code_width_q + WidthBits'(1);
          end
        end
        prev_code_d  = code_q;
        prev_valid_d = 1'b1;
        prev_first_d = root_q;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          pixel_d     = stk_rdata;
          status_d    = ST_PIXEL;
          level_d     = level_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      phase_q         <= PH_RUN;
      min_code_size_q <= MinCodeReset;
      active_min_q    <= MinCodeHigh;
      code_width_q    <= WidthBits'(MinCodeHigh) + WidthBits'(1);
      next_free_q     <= (NB'(1) << MinCodeHigh) + NB'(2);
      prev_code_q     <= '0;
      prev_valid_q    <= 1'b0;
      prev_first_q    <= '0;
      kwk_q           <= 1'b0;
      level_q         <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      active_min_q <= active_min_d;
      code_width_q <= code_width_d;
      next_free_q  <= next_free_d;
      prev_code_q  <= prev_code_d;
      prev_valid_q <= prev_valid_d;
      prev_first_q <= prev_first_d;
      kwk_q        <= kwk_d;
      level_q      <= level_d;
      out_valid_q  <= out_valid_d;
      if (cfg_write) begin
        min_code_size_q <= pwdata[MinBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    cur_q    <= cur_d;
    root_q   <= root_d;
    pixel_q  <= pixel_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign status_o    = status_q;

  gld_bitbuf #(
    .CodeBits(CB)
  ) u_bitbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (bb_ctrl),
    .byte_i (data_byte_i),
    .width_i(code_width_q),
    .code_o (bb_code),
    .count_o(bb_count)
  );

  gld_dict #(
    .CodeBits(CB)
  ) u_dict (
    .clk_i      (clk_i),
    .wr_en_i    (dict_we),
    .wr_addr_i  (dict_waddr),
    .wr_prefix_i(dict_wprefix),
    .wr_suffix_i(dict_wsuffix),
    .rd_addr_i  (dict_raddr),
    .rd_prefix_o(dict_rprefix),
    .rd_suffix_o(dict_rsuffix)
  );

  gld_stack #(
    .AddrBits(CB)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (stk_we),
    .wr_addr_i(level_q[CB-1:0]),
    .wr_data_i(stk_wdata),
    .rd_addr_i(level_dec[CB-1:0]),
    .rd_data_o(stk_rdata)
  );

  // The stack never holds more bytes than the dictionary has codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni) level_q <= TableSize)
    else $error("string stack level out of range");

  // A pixel is only emitted from a nonempty stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> level_q != '0)
    else $error("pixel emit with empty stack");

  // The code width stays within the supported range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_width_q <= WidthBits'(MAX_CODE_BITS) && code_width_q >= WidthBits'(3))
    else $error("code width out of range");

  // Pushing the root symbol grows the stack by exactly one entry and moves on to S_POP.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROOT |=> level_q == $past(level_q) + NB'(1) && state_q == S_POP)
    else $error("root push did not advance the stack");

endmodule

// File: sim/tb_gif_lzw_decoder.sv
// Testbench for the GIF LZW decoder: directed requests, generated LZW streams and a scoreboard.
`timescale 1ns / 1ps

module tb_gif_lzw_decoder;
  import gld_pkg::*;

  localparam int CodeBitsMax = 12;
  localparam int TableSize   = 1 << CodeBitsMax;
  localparam int StallLimit  = 20000;
  localparam int PhaseItems  = 50;

  typedef struct packed {
    logic [7:0] pixel;
    status_e    status;
  } pixel_result_t;

  typedef struct packed {
    mode_e         mode;
    logic [7:0]    data;
    bit            typed;
    pixel_result_t res;
  } dir_row_t;

  localparam dir_row_t DirRows [27] = '{
    '{MODE_PULL,  8'h00, 1'b1, '{8'h00, ST_NEED}},
    '{MODE_PUSH,  8'h00, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PUSH,  8'hFF, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PUSH,  8'h01, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PUSH,  8'h18, 1'b1, '{8'h00, ST_REFUSED}},
    '{MODE_PULL,  8'h00, 1'b1, '{8'hFF, ST_PIXEL}},
    '{MODE_PULL,  8'h00, 1'b1, '{8'h00, ST_NEED}},
    '{MODE_PUSH,  8'h18, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PUSH,  8'h18, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PULL,  8'h00, 1'b0, '{8'h00, ST_PIXEL}},
    '{MODE_PULL,  8'h00, 1'b0, '{8'h00, ST_PIXEL}},
    '{MODE_PULL,  8'h00, 1'b0, '{8'h00, ST_PIXEL}},
    '{MODE_PULL,  8'h00, 1'b1, '{8'h00, ST_NEED}},
    '{MODE_PUSH,  8'h10, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PULL,  8'h00, 1'b1, '{8'h00, ST_END}},
    '{MODE_PULL,  8'h00, 1'b1, '{8'h00, ST_END}},
    '{MODE_PUSH,  8'hAB, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_NONE,  8'h5A, 1'b0, '{8'h00, ST_PIXEL}},
    '{MODE_START, 8'hA5, 1'b0, '{8'h00, ST_PIXEL}},
    '{MODE_PULL,  8'h00, 1'b1, '{8'h00, ST_NEED}},
    '{MODE_PUSH,  8'hFF, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PUSH,  8'hFF, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PUSH,  8'hFF, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_PULL,  8'h00, 1'b1, '{8'h00, ST_ILLEGAL}},
    '{MODE_PULL,  8'h00, 1'b1, '{8'h00, ST_ILLEGAL}},
    '{MODE_PUSH,  8'h00, 1'b1, '{8'h00, ST_TAKEN}},
    '{MODE_START, 8'h00, 1'b0, '{8'h00, ST_PIXEL}}
  };

  localparam logic [3:0] PhaseMin [9] = '{4'd15, 4'd0, 4'd5, 4'd8, 4'd3, 4'd9, 4'd1, 4'd6, 4'd2};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_NONE;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  pixel_o;
  logic [2:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 11;
  int recv_idle_pct = 66;
  int mismatches = 0;
  int stall_cycles = 0;
  int items_left = 0;

  pixel_result_t expected_pixels [$];

  logic [3:0]  cfg_min_code = MinCodeReset;
  int          act_min;
  bit [11:0]   dict_prefix [TableSize];
  bit [7:0]    dict_suffix [TableSize];
  bit [7:0]    dict_first  [TableSize];
  int          free_code;
  int          last_code;
  bit          last_valid;
  int          code_bits;
  logic [23:0] bit_buf;
  int          buf_fill;
  bit [7:0]    pixel_stack [TableSize];
  int          stack_depth;
  phase_e      dec_phase;

  logic [7:0]  comp_bytes [$];
  logic [31:0] pack_bits;
  int          pack_n;

  function automatic int clear_code_of();
    return 1 << act_min;
  endfunction

  function automatic void dict_restart();
    code_bits  = act_min + 1;
    free_code  = clear_code_of() + 2;
    last_code  = 0;
    last_valid = 1'b0;
  endfunction

  function automatic void image_restart();
    if (cfg_min_code < MinCodeLow) act_min = MinCodeLow;
    else if (cfg_min_code > MinCodeHigh) act_min = MinCodeHigh;
    else act_min = cfg_min_code;
    dict_restart();
    bit_buf     = '0;
    buf_fill    = 0;
    stack_depth = 0;
    dec_phase   = PH_RUN;
  endfunction

  function automatic bit [7:0] first_symbol(int c);
    return (c < clear_code_of()) ? 8'(c) : dict_first[c];
  endfunction

  function automatic void dict_append(bit [7:0] sfx);
    dict_prefix[free_code] = 12'(last_code);
    dict_first[free_code]  = first_symbol(last_code);
    dict_suffix[free_code] = sfx;
    free_code++;
    if (free_code == (1 << code_bits) && free_code < TableSize) code_bits++;
  endfunction

  function automatic void push_string(int code);
    int c;
    int n;
    c = code;
    stack_depth = 0;
    for (n = 0; n <= TableSize; n++) begin
      if (stack_depth >= TableSize) break;
      if (c < clear_code_of()) begin
        pixel_stack[stack_depth] = 8'(c);
        stack_depth++;
        break;
      end
      pixel_stack[stack_depth] = dict_suffix[c];
      stack_depth++;
      c = dict_prefix[c];
    end
  endfunction

  function automatic status_e decode_next();
    int code;
    int clr;
    while (1'b1) begin
      if (dec_phase == PH_END) return ST_END;
      if (dec_phase != PH_RUN) return ST_ILLEGAL;
      if (buf_fill < code_bits) return ST_NEED;
      code = int'(bit_buf) & ((1 << code_bits) - 1);
      bit_buf = bit_buf >> code_bits;
      buf_fill -= code_bits;
      clr = clear_code_of();
      if (code == clr + 1) begin
        dec_phase = PH_END;
        return ST_END;
      end
      if (code == clr) begin
        dict_restart();
        continue;
      end
      if (code < free_code) begin
        push_string(code);
        if (last_valid && free_code < TableSize) dict_append(first_symbol(code));
      end else if (code == free_code && last_valid && free_code < TableSize) begin
        dict_append(first_symbol(last_code));
        push_string(code);
      end else begin
        dec_phase = PH_ERR;
        return ST_ILLEGAL;
      end
      last_code  = code;
      last_valid = 1'b1;
      return ST_PIXEL;
    end
    return ST_ILLEGAL;
  endfunction

  function automatic bit lzw_decode_step(mode_e m, logic [7:0] b, output logic [7:0] pix,
                                         output status_e st);
    pix = '0;
    st  = ST_PIXEL;
    case (m)
      MODE_START: begin
        image_restart();
        return 1'b0;
      end
      MODE_NONE: return 1'b0;
      MODE_PUSH: begin
        if (buf_fill > PushLimit) begin
          st = ST_REFUSED;
        end else begin
          bit_buf  = bit_buf | (24'(b) << buf_fill);
          buf_fill += 8;
          st = ST_TAKEN;
        end
      end
      default: begin
        if (stack_depth == 0) st = decode_next();
        if (st == ST_PIXEL && stack_depth > 0) begin
          stack_depth--;
          pix = pixel_stack[stack_depth];
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void pack_code(int code, int width);
    pack_bits = pack_bits | (32'(code) << pack_n);
    pack_n += width;
    while (pack_n >= 8) begin
      comp_bytes.push_back(pack_bits[7:0]);
      pack_bits = pack_bits >> 8;
      pack_n -= 8;
    end
  endfunction

  // Builds a code stream for the active code size. Unfilled: rare clear codes, an occasional
  // illegal code that ends the stream, mostly an end code. Filled: two clear codes, always an end code.
  function automatic void build_stream(int n_codes, bit fill);
    int clr;
    int nf;
    int width;
    int code;
    int roll;
    int lo;
    int i;
    bit pv;
    bit broken;
    logic [7:0] pad;
    clr    = 1 << act_min;
    nf     = clr + 2;
    width  = act_min + 1;
    pv     = 1'b0;
    broken = 1'b0;
    comp_bytes.delete();
    pack_bits = '0;
    pack_n    = 0;
    if (fill || $urandom_range(1) == 1) pack_code(clr, width);
    for (i = 0; i < n_codes && !broken; i++) begin
      roll = $urandom_range(99);
      if (fill ? (i == n_codes - 24) : (roll < 3)) begin
        pack_code(clr, width);
        nf    = clr + 2;
        width = act_min + 1;
        pv    = 1'b0;
      end else if (!fill && roll == 3 && (!pv || nf < (1 << width) - 1)) begin
        pack_code(pv ? $urandom_range((1 << width) - 1, nf + 1) : nf, width);
        broken = 1'b1;
      end else begin
        if (!fill && pv && nf < TableSize && roll < 14) begin
          code = nf;
        end else if (nf == clr + 2 || roll < (fill ? 90 : 45)) begin
          code = $urandom_range(clr - 1, 0);
        end else begin
          lo = (roll < 70 && nf - 4 > clr + 2) ? nf - 4 : clr + 2;
          code = $urandom_range(nf - 1, lo);
        end
        pack_code(code, width);
        if (pv && nf < TableSize) begin
          nf++;
          if (nf == (1 << width) && nf < TableSize) width++;
        end
        pv = 1'b1;
      end
    end
    if (!broken && (fill || $urandom_range(99) < 85)) pack_code(clr + 1, width);
    if (pack_n > 0) begin
      pad = $urandom;
      comp_bytes.push_back(pack_bits[7:0] | (pad << pack_n));
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_req(input mode_e m, input logic [7:0] b, input bit typed,
                          input pixel_result_t typed_res);
    logic [7:0]    pix;
    status_e       st;
    pixel_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (lzw_decode_step(m, b, pix, st)) begin
      predicted.pixel  = pix;
      predicted.status = st;
      if (typed) expected_pixels.push_back(typed_res);
      else expected_pixels.push_back(predicted);
    end
  endtask

  task automatic send_item(input mode_e m, input logic [7:0] b);
    send_req(m, b, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_MIN_CODE_SIZE, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (!wr && prdata[3:0] !== val[3:0]) report_mismatch("min_code_size readback", prdata, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_min_code(input logic [3:0] val);
    wait_drained();
    repeat (16) @(posedge clk_i);
    apb_access(1'b1, 32'(val));
    cfg_min_code = val;
    apb_access(1'b0, 32'(val));
  endtask

  task automatic play_image(input int n_codes, input bit fill);
    int idx;
    int tail;
    int roll;
    logic [7:0] byte_now;
    idx  = 0;
    tail = $urandom_range(3, 1);
    send_item(MODE_START, 8'($urandom));
    build_stream(n_codes, fill);
    while (fill || items_left > 0) begin
      roll = $urandom_range(99);
      if (!fill && roll == 0) wait_drained();
      if (!fill && roll >= 97) begin
        send_item(MODE_NONE, 8'($urandom));
      end else begin
        if (idx < comp_bytes.size() && (buf_fill <= PushLimit ? roll < 65 : roll < 5)) begin
          byte_now = comp_bytes[idx];
          if (buf_fill <= PushLimit) idx++;
          send_item(MODE_PUSH, byte_now);
        end else begin
          if (idx >= comp_bytes.size() && stack_depth == 0 &&
              (dec_phase != PH_RUN || buf_fill < code_bits)) begin
            if (tail == 0) break;
            tail--;
          end
          send_item(MODE_PULL, 8'($urandom));
        end
        if (!fill) items_left--;
      end
    end
  endtask

  gif_lzw_decoder #(
    .MAX_CODE_BITS(CodeBitsMax)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_o    (pixel_o),
    .status_o   (status_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    pixel_result_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no request pending, status", status_o, -1);
      end else begin
        head = expected_pixels.pop_front();
        if (pixel_o !== head.pixel) report_mismatch("pixel", pixel_o, head.pixel);
        if (status_o !== head.status) report_mismatch("status", status_o, head.status);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    image_restart();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, 32'(MinCodeReset));
    foreach (DirRows[i]) begin
      send_req(DirRows[i].mode, DirRows[i].data, DirRows[i].typed, DirRows[i].res);
    end
    for (ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 11;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_min_code(PhaseMin[ph]);
      if (ph == 8) begin
        play_image(40, 1'b1);
      end else begin
        repeat (2) send_item(MODE_PULL, 8'($urandom));
        items_left = PhaseItems;
        while (items_left > 0) play_image($urandom_range(16, 3), 1'b0);
      end
    end
    wait_drained();
    repeat (32) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: gif_lzw_decoder.f
src/gld_pkg.sv
src/gld_bitbuf.sv
src/gld_dict.sv
src/gld_stack.sv
src/gif_lzw_decoder.sv
sim/tb_gif_lzw_decoder.sv
